>>> hdl/quaternion_euler_rotate_direction_core_assert.svh
// Assertion macros shared by the core.
`ifndef QUATERNION_EULER_ROTATE_DIRECTION_CORE_ASSERT_SVH
`define QUATERNION_EULER_ROTATE_DIRECTION_CORE_ASSERT_SVH

// A condition implies a consequence on the same edge.
`define QER_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("implication failed");

// A condition implies a consequence on the next edge.
`define QER_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hdl/qer_pkg.sv
package qer_pkg;

  localparam int CordicSteps = 16;
  localparam int FracBits    = 14;
  localparam int AngW        = 36;
  localparam int XyW         = FracBits + 4;

  // Scaling from the CORDIC datapath to Q2.14: shift up exactly, or round half up.
  localparam int UpSh = (FracBits > 14) ? 0 : 14 - FracBits;
  localparam int DnSh = (FracBits > 14) ? FracBits - 14 : 0;
  localparam logic signed [40:0] RndQ = (DnSh > 0) ? (41'sd1 <<< (DnSh - 1)) : 41'sd0;

  localparam logic signed [AngW-1:0] Deg90  = 36'sd1509949440;
  localparam logic signed [AngW-1:0] Deg180 = 36'sd3019898880;
  localparam logic signed [63:0] GainRnd =
    (64'sd652032874 + ((64'sd1 <<< (30 - FracBits)) >>> 1)) >>> (30 - FracBits);
  localparam logic signed [XyW-1:0] GainInit = XyW'(GainRnd);

  typedef logic [4:0] step_idx_t;

  function automatic logic signed [AngW-1:0] atan_lut(input step_idx_t i);
    logic signed [AngW-1:0] v;
    case (i)
      5'd0: v = 36'sd754974720;   5'd1: v = 36'sd445687602;
      5'd2: v = 36'sd235489088;   5'd3: v = 36'sd119537938;
      5'd4: v = 36'sd60000934;    5'd5: v = 36'sd30029717;
      5'd6: v = 36'sd15018523;    5'd7: v = 36'sd7509720;
      5'd8: v = 36'sd3754917;     5'd9: v = 36'sd1877466;
      5'd10: v = 36'sd938734;     5'd11: v = 36'sd469367;
      5'd12: v = 36'sd234684;     5'd13: v = 36'sd117342;
      5'd14: v = 36'sd58671;      5'd15: v = 36'sd29335;
      5'd16: v = 36'sd14668;      5'd17: v = 36'sd7334;
      5'd18: v = 36'sd3667;       5'd19: v = 36'sd1833;
      5'd20: v = 36'sd917;        5'd21: v = 36'sd458;
      5'd22: v = 36'sd229;        5'd23: v = 36'sd115;
      5'd24: v = 36'sd57;         5'd25: v = 36'sd29;
      5'd26: v = 36'sd14;         5'd27: v = 36'sd7;
      5'd28: v = 36'sd4;          5'd29: v = 36'sd2;
      5'd30: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
    if (v > 41'sd32767) return 16'sh7fff;
    if (v < -41'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_MUL, ST_ROUND, ST_DONE
  } state_t;

endpackage

>>> hdl/qer_cordic.sv
module qer_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [15:0]    angle,
  output logic                  done,
  output logic signed [15:0]    sin_q14,
  output logic signed [15:0]    cos_q14
);
  import qer_pkg::*;

  logic signed [XyW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [AngW-1:0] z_r, z_nxt, z0;
  logic                   neg_r, neg_nxt, busy_r, busy_nxt, done_r;
  step_idx_t              i_r, i_nxt;
  logic signed [XyW-1:0]  xf, yf;
  logic signed [40:0]     xq, yq;

  always_comb begin
    z0 = AngW'(angle) <<< 17;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; neg_nxt = neg_r;
    i_nxt = i_r; busy_nxt = busy_r;
    if (start) begin
      neg_nxt = (z0 > Deg90) || (z0 < -Deg90);
      z_nxt = (z0 > Deg90) ? z0 - Deg180 : ((z0 < -Deg90) ? z0 + Deg180 : z0);
      x_nxt = GainInit; y_nxt = '0; i_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      // One micro-rotation per cycle through the shared shifter pair.
      if (z_r >= 0) begin
        x_nxt = x_r - (y_r >>> i_r); y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - atan_lut(i_r);
      end else begin
        x_nxt = x_r + (y_r >>> i_r); y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + atan_lut(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == step_idx_t'(CordicSteps - 1)) busy_nxt = 1'b0;
    end
  end

  // done rises on the edge that stores the last micro-rotation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; i_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; i_r <= i_nxt;
      done_r <= busy_r && (i_r == step_idx_t'(CordicSteps - 1));
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; neg_r <= neg_nxt;
  end

  always_comb begin
    xf = neg_r ? -x_r : x_r;
    yf = neg_r ? -y_r : y_r;
    xq = ((41'(xf) <<< UpSh) + RndQ) >>> DnSh;
    yq = ((41'(yf) <<< UpSh) + RndQ) >>> DnSh;
  end

  assign done    = done_r;
  assign sin_q14 = sat16(yq);
  assign cos_q14 = sat16(xq);
endmodule

>>> hdl/quaternion_euler_rotate_direction_core.sv
// Orientation update core.
// Input channel in_valid/in_ready carries three angle increments per beat
// (1/128 degree). The output channel out_valid/out_ready carries the rotated
// forward direction and the new orientation quaternion, both Q2.14.
// One input beat yields exactly one output beat. in_ready is high only while
// the core is idle; each item runs three CORDIC passes in one shared CORDIC
// unit, then five quaternion products, each of four rows that accumulate
// four partial products and then round. The CORDIC is serial, and one
// single shared 16x16 multiplier-accumulator serves all the products.
// The result is held in output registers until out_ready, while the next item
// is accepted and worked on; that item then waits at its end until the
// output registers are free.
// Reset sets the orientation to (1,0,0,0) and empties the pipeline.
// A stalled receiver holds the result; after one more item in_ready stays low.
module quaternion_euler_rotate_direction_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic signed [15:0] out_orient_w,
  output logic signed [15:0] out_orient_x,
  output logic signed [15:0] out_orient_y,
  output logic signed [15:0] out_orient_z
);
  import qer_pkg::*;
  `include "quaternion_euler_rotate_direction_core_assert.svh"

  typedef logic signed [15:0] q_t [4];

  state_t state_r, state_nxt;
  q_t ori_r, ori_nxt, qa_r, qa_nxt, qb_r, qb_nxt, acc_r, acc_nxt;
  q_t qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt, dir_r, dir_nxt;
  q_t res_ori_r, res_ori_nxt;
  logic signed [15:0] ay_r, az_r;
  logic [1:0] ang_r, ang_nxt;        // which angle the CORDIC works on
  logic [2:0] prod_r, prod_nxt;      // which of the five products
  logic [3:0] term_r, term_nxt;      // partial product: row, column
  logic signed [35:0] mac_r, mac_nxt;
  logic out_valid_r, out_valid_nxt;
  logic cstart, cdone;
  logic signed [15:0] csin, ccos, cang;
  logic signed [15:0] mop_a, mop_b;
  logic signed [31:0] mprod;
  logic               mneg;
  logic [1:0] row, col, bidx;
  logic signed [40:0] rnd;
  logic signed [15:0] fwd_in, prod_out;

  assign row = term_r[3:2];
  assign col = term_r[1:0];

  qer_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .angle(cang),
    .done(cdone), .sin_q14(csin), .cos_q14(ccos)
  );

  // The CORDIC starts on the accepting edge, so the first angle comes
  // straight from the port; later passes use the angle about to be worked on.
  always_comb begin
    case (ang_nxt)
      2'd1: cang = ay_r;
      2'd2: cang = az_r;
      default: cang = in_angle_x;
    endcase
  end

  // Hamilton product: result row r accumulates a[c] * b[idx] with a sign.
  always_comb begin
    bidx = row ^ col;
    case ({row, col})
      4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: mneg = 1'b1;
      default: mneg = 1'b0;
    endcase
    mop_a = qa_r[col];
    mop_b = qb_r[bidx];
    mprod = mop_a * mop_b;
    rnd = (41'(mac_r) + 41'sd8192) >>> 14;
    prod_out = sat16(rnd);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CORDIC;
      ST_CORDIC: if (cdone && ang_r == 2'd2) state_nxt = ST_MUL;
      ST_MUL:    if (col == 2'd3) state_nxt = ST_ROUND;
      ST_ROUND:  if (row == 2'd0 && prod_r == 3'd4) state_nxt = ST_DONE;
                 else state_nxt = ST_MUL;
      ST_DONE:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ori_nxt = ori_r; qa_nxt = qa_r; qb_nxt = qb_r; acc_nxt = acc_r;
    qx_nxt = qx_r; qy_nxt = qy_r; qz_nxt = qz_r; dir_nxt = dir_r;
    res_ori_nxt = res_ori_r;
    ang_nxt = ang_r; prod_nxt = prod_r; term_nxt = term_r; mac_nxt = mac_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cstart = 1'b0;
    fwd_in = -16'sd16384;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ang_nxt = 2'd0; cstart = 1'b0;
        end
      end
      ST_CORDIC: begin
        if (cdone) begin
          case (ang_r)
            2'd0: qx_nxt = '{ccos, csin, 16'sd0, 16'sd0};
            2'd1: qy_nxt = '{ccos, 16'sd0, csin, 16'sd0};
            default: qz_nxt = '{ccos, 16'sd0, 16'sd0, csin};
          endcase
          ang_nxt = ang_r + 2'd1;
          if (ang_r == 2'd2) begin
            qa_nxt = qy_r; qb_nxt = ori_r;
            qa_nxt[0] = qy_r[0]; prod_nxt = '0; term_nxt = '0; mac_nxt = '0;
          end
        end
      end
      ST_MUL: begin
        mac_nxt = mneg ? mac_r - 36'(mprod) : mac_r + 36'(mprod);
        term_nxt = term_r + 4'd1;
      end
      ST_ROUND: begin
        acc_nxt[row - 2'd1] = prod_out;
        mac_nxt = '0;
        if (row == 2'd0) begin
          // Row counter already wrapped: the whole product is complete.
          acc_nxt[3] = prod_out;
          prod_nxt = prod_r + 3'd1;
          case (prod_r)
            3'd0: begin qa_nxt = acc_nxt; qb_nxt = qx_r; end
            3'd1: begin qa_nxt = acc_nxt; qb_nxt = qz_r; end
            3'd2: begin
              ori_nxt = acc_nxt; qa_nxt = acc_nxt;
              qb_nxt = '{16'sd0, 16'sd0, 16'sd0, fwd_in};
            end
            3'd3: begin
              qa_nxt = acc_nxt;
              qb_nxt[0] = ori_r[0];
              qb_nxt[1] = sat16(-41'(ori_r[1]));
              qb_nxt[2] = sat16(-41'(ori_r[2]));
              qb_nxt[3] = sat16(-41'(ori_r[3]));
            end
            default: ;
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          dir_nxt = acc_r;
          res_ori_nxt = ori_r;
        end
      end
      default: ;
    endcase
    if (state_r == ST_IDLE && in_valid) cstart = 1'b1;
    if (state_r == ST_CORDIC && cdone && ang_r != 2'd2) cstart = 1'b1;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      ori_r <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      ang_r <= '0; prod_r <= '0; term_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ori_r <= ori_nxt;
      ang_r <= ang_nxt; prod_r <= prod_nxt; term_r <= term_nxt;
    end
    if (in_valid && in_ready) begin
      ay_r <= in_angle_y; az_r <= in_angle_z;
    end
    qa_r <= qa_nxt; qb_r <= qb_nxt; acc_r <= acc_nxt; mac_r <= mac_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt; qz_r <= qz_nxt; dir_r <= dir_nxt;
    res_ori_r <= res_ori_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_dir_x    = dir_r[1];
  assign out_dir_y    = dir_r[2];
  assign out_dir_z    = dir_r[3];
  assign out_orient_w = res_ori_r[0];
  assign out_orient_x = res_ori_r[1];
  assign out_orient_y = res_ori_r[2];
  assign out_orient_z = res_ori_r[3];

  `QER_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != ST_IDLE, !in_ready)
  `QER_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid)
  `QER_ASSERT_NEXT(a_done_valid, clk, rst_n,
    state_r == ST_DONE && state_nxt == ST_IDLE, out_valid)
endmodule
